// ===== sv/ndlms_pkg.sv =====
// shared constants and types for the note driven led matrix scanner
// no dependencies; imported by every module of the block
`default_nettype none

package ndlms_pkg;

    localparam int NDLMS_ROWS = 8;
    localparam int NDLMS_COLS = 8;

    localparam int STATUS_W   = 8;
    localparam int NOTE_W     = 7;
    localparam int COLOUR_W   = 7;
    localparam int ROW_OUT_W  = 3;
    localparam int MASK_W     = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [3:0]        NOTE_ON_NIBBLE = 4'h9;
    localparam logic [NOTE_W-1:0] CLEAR_NOTE     = 7'h7C;

    // colour bits that feed the three column planes
    localparam int PLANE4_BIT = 4;
    localparam int PLANE5_BIT = 5;
    localparam int PLANE6_BIT = 6;

    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } t_ram_cmd;

    // row_off sits in the lowest bits
    typedef struct packed {
        logic [MASK_W-1:0]    p6;
        logic [MASK_W-1:0]    p5;
        logic [MASK_W-1:0]    p4;
        logic [ROW_OUT_W-1:0] row_on;
        logic [ROW_OUT_W-1:0] row_off;
    } t_scan_res;

endpackage

`default_nettype wire

// ===== sv/ndlms_cell_ram.sv =====
// colour cell store: one write port, one registered read port, per-entry valid bits
// depends on ndlms_pkg
`default_nettype none

module ndlms_cell_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ndlms_pkg::t_ram_cmd           i_cmd,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [ndlms_pkg::COLOUR_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [ndlms_pkg::COLOUR_W-1:0] o_rd_data
);
    import ndlms_pkg::*;

    logic [COLOUR_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;
    logic [COLOUR_W-1:0] r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a clear drops every valid bit at once, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_valid <= '0;
            end else if (i_cmd.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== sv/ndlms_ctrl.sv =====
// event decoder and scan sequencer: writes notes, walks one row of cells per tick
// depends on ndlms_pkg and drives ndlms_cell_ram
`default_nettype none

module ndlms_ctrl #(
    parameter int ROWS = 8,
    parameter int COLS = 8,
    parameter int AW   = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_vld,
    output logic                                o_in_rdy,
    input  wire logic                           i_mode,
    input  wire logic [ndlms_pkg::STATUS_W-1:0] i_status,
    input  wire logic [ndlms_pkg::NOTE_W-1:0]   i_note,
    input  wire logic [ndlms_pkg::COLOUR_W-1:0] i_vel,
    output ndlms_pkg::t_ram_cmd                 o_cmd,
    output logic      [AW-1:0]                  o_wr_addr,
    output logic      [ndlms_pkg::COLOUR_W-1:0] o_wr_data,
    output logic      [AW-1:0]                  o_rd_addr,
    input  wire logic [ndlms_pkg::COLOUR_W-1:0] i_rd_data,
    output logic                                o_res_vld,
    input  wire logic                           i_res_rdy,
    output ndlms_pkg::t_scan_res                o_res
);
    import ndlms_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [8:0] CELLS_9 = 9'(CELLS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [RW-1:0]   r_cur_row;
    logic [RW-1:0]   r_new_row;
    logic [AW-1:0]   r_base;
    logic [AW-1:0]   r_new_base;
    logic [AW-1:0]   r_addr;
    logic [CW-1:0]   r_col;
    logic            r_pend;
    logic [CW-1:0]   r_pend_col;
    logic [MASK_W-1:0] r_p4;
    logic [MASK_W-1:0] r_p5;
    logic [MASK_W-1:0] r_p6;

    logic            in_acc;
    logic            note_on;
    logic [8:0]      note_ext;
    logic            in_cells;
    logic            row_last;
    logic [RW-1:0]   n_row;
    logic [AW-1:0]   n_base;
    logic            col_last;
    logic [RW+ROW_OUT_W-1:0] cur_ext;
    logic [RW+ROW_OUT_W-1:0] new_ext;

    assign o_in_rdy = (r_state == S_IDLE);
    assign in_acc   = i_in_vld && o_in_rdy;
    assign note_on  = (i_status[STATUS_W-1:4] == NOTE_ON_NIBBLE);
    assign note_ext = {2'b00, i_note};
    // cell range is tested before the clear note
    assign in_cells = (note_ext >= 9'd1) && (note_ext <= CELLS_9);

    assign o_cmd.wr  = in_acc && !i_mode && note_on && in_cells;
    assign o_cmd.clr = in_acc && !i_mode && note_on && !in_cells && (i_note == CLEAR_NOTE);
    assign o_cmd.rd  = (r_state == S_READ);
    assign o_wr_addr = AW'(note_ext - 9'd1);
    assign o_wr_data = i_vel;
    assign o_rd_addr = r_addr;

    assign row_last = (r_cur_row == RW'(ROWS - 1));
    assign n_row    = row_last ? '0 : r_cur_row + 1'b1;
    assign n_base   = row_last ? '0 : r_base + AW'(COLS);
    assign col_last = (r_col == CW'(COLS - 1));

    assign cur_ext = {{ROW_OUT_W{1'b0}}, r_cur_row};
    assign new_ext = {{ROW_OUT_W{1'b0}}, r_new_row};

    assign o_res_vld     = (r_state == S_DONE);
    assign o_res.row_off = cur_ext[ROW_OUT_W-1:0];
    assign o_res.row_on  = new_ext[ROW_OUT_W-1:0];
    assign o_res.p4      = r_p4;
    assign o_res.p5      = r_p5;
    assign o_res.p6      = r_p6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur_row <= '0;
            r_base    <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_pend     <= (r_state == S_READ);
            r_pend_col <= r_col;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode) begin
                        r_new_row  <= n_row;
                        r_new_base <= n_base;
                        r_addr     <= n_base;
                        r_col      <= '0;
                        r_p4       <= '0;
                        r_p5       <= '0;
                        r_p6       <= '0;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_addr <= r_addr + 1'b1;
                    r_col  <= r_col + 1'b1;
                    if (col_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_rdy) begin
                        r_cur_row <= r_new_row;
                        r_base    <= r_new_base;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // read data lands in the cycle after its address; columns past the mask drop out
            if (r_pend) begin
                for (int c = 0; c < MASK_W; c++) begin
                    if (c < COLS && r_pend_col == CW'(c)) begin
                        r_p4[c] <= i_rd_data[PLANE4_BIT];
                        r_p5[c] <= i_rd_data[PLANE5_BIT];
                        r_p6[c] <= i_rd_data[PLANE6_BIT];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/note_driven_led_matrix_scanner.sv =====
// A note event (tuser = 0) acts as it is accepted: a note-on for note 1..ROWS*COLS writes its
// velocity into cell note-1 and note 0x7C empties the whole store at once through per-cell
// valid bits, so no clearing pass runs after reset or clear. A scan tick (tuser = 1) walks
// its row: the row's cells are read one per cycle through the single read port of the cell
// store, then a drain state waits out the read latency and a done state hands the word to
// the output register once it has room. The output register lets the next input be taken
// while a scan word still waits downstream.
// depends on ndlms_pkg, ndlms_cell_ram and ndlms_ctrl
`default_nettype none

module note_driven_led_matrix_scanner #(
    parameter int ROWS = ndlms_pkg::NDLMS_ROWS,
    parameter int COLS = ndlms_pkg::NDLMS_COLS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // status_byte [7:0], note_number [14:8], velocity [21:15], zero [23:22]
    input  wire logic [ndlms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode [0]
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // row_off [2:0], row_on [5:3], plane_bit4_cols [13:6], plane_bit5_cols [21:14],
    // plane_bit6_cols [29:22], zero [31:30]
    output logic      [ndlms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ndlms_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    t_ram_cmd           cmd;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [COLOUR_W-1:0] wr_data;
    logic [COLOUR_W-1:0] rd_data;
    logic               res_vld;
    logic               res_rdy;
    t_scan_res          res;

    logic               r_out_vld;
    t_scan_res          r_out_res;

    ndlms_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_status  (s_axis_tdata[7:0]),
        .i_note    (s_axis_tdata[14:8]),
        .i_vel     (s_axis_tdata[21:15]),
        .o_cmd     (cmd),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res)
    );

    ndlms_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (res_vld && res_rdy) begin
                r_out_vld <= 1'b1;
                r_out_res <= res;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_res);

endmodule

`default_nettype wire

// ===== sv/ndlms_chk.sv =====
// port-level checks on the scan word stream of the led matrix scanner
// depends on ndlms_pkg; bound to note_driven_led_matrix_scanner below
`default_nettype none

module ndlms_chk #(
    parameter int ROWS = ndlms_pkg::NDLMS_ROWS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [ndlms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ndlms_pkg::*;

    logic [ROW_OUT_W-1:0] r_last_on;
    logic [ROW_OUT_W-1:0] row_off;
    logic [ROW_OUT_W-1:0] row_on;

    assign row_off = m_axis_tdata[2:0];
    assign row_on  = m_axis_tdata[5:3];

    // row switched on by the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_on <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_last_on <= row_on;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("scan word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled scan word changed");

    a_row_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> row_off == r_last_on)
        else $error("row to switch off is not the row last switched on");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (ROWS > 8) ||
            (row_on == ((row_off == 3'(ROWS - 1)) ? 3'd0 : row_off + 3'd1)))
        else $error("row to switch on does not follow the previous row");

endmodule

bind note_driven_led_matrix_scanner ndlms_chk #(
    .ROWS (ROWS)
) u_ndlms_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking bench for the note driven led matrix scanner: note events and scan ticks
// go in as stream words, a local copy of the colour store predicts every scan word
// depends on ndlms_pkg and note_driven_led_matrix_scanner
`timescale 1ns / 1ps

module testbench;

    import ndlms_pkg::*;

    localparam int ROWS       = NDLMS_ROWS;
    localparam int COLS       = NDLMS_COLS;
    localparam int CELLS      = ROWS * COLS;
    localparam int FIRST_NOTE = 1;
    localparam int MAX_WAIT   = 17;
    localparam int RAND_ITEMS = 1700;

    localparam logic MODE_NOTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [3:0] OFF_NIBBLE = 4'h8;

    typedef struct {
        logic       mode;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        int         gap;
        bit         drain;
    } t_midi_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // status_byte [7:0], note_number [14:8], velocity [21:15], zero [23:22]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // mode [0]
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // row_off [2:0], row_on [5:3], plane_bit4_cols [13:6], plane_bit5_cols [21:14],
    // plane_bit6_cols [29:22], zero [31:30]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_midi_item pending_events[$];
    t_scan_res  scan_words_due[$];

    logic [COLOUR_W-1:0] colours [CELLS];
    int cur_row;
    int prev_row;

    int errors     = 0;
    int n_writes   = 0;
    int n_clears   = 0;
    int n_ignored  = 0;
    int n_checked  = 0;
    bit sender_burst = 1'b0;

    note_driven_led_matrix_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on scan word %0d: %s got 0x%0h want 0x%0h",
                 n_checked, what, got, want);
        errors++;
    endtask

    task automatic queue_event(input logic mode, input logic [7:0] status,
                               input logic [6:0] note, input logic [6:0] vel,
                               input bit drain);
        t_midi_item it;
        it.mode   = mode;
        it.status = status;
        it.note   = note;
        it.vel    = vel;
        it.drain  = drain;
        it.gap    = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        pending_events.push_back(it);
    endtask

    // apply one accepted word to the local store, queue the scan word a tick produces
    task automatic update_matrix(input t_midi_item it);
        t_scan_res w;
        int        row;
        int        cell_idx;
        if (it.mode == MODE_NOTE) begin
            if (it.status[7:4] != NOTE_ON_NIBBLE) begin
                n_ignored++;
            end else if (it.note >= FIRST_NOTE && it.note <= CELLS) begin
                colours[it.note - FIRST_NOTE] = it.vel;
                n_writes++;
            end else if (it.note == CLEAR_NOTE) begin
                foreach (colours[i]) colours[i] = '0;
                n_clears++;
            end else begin
                n_ignored++;
            end
        end else begin
            row = (cur_row + 1) % ROWS;
            w = '0;
            w.row_off = ROW_OUT_W'(prev_row);
            w.row_on  = ROW_OUT_W'(row);
            for (int c = 0; c < COLS && c < MASK_W; c++) begin
                cell_idx = row * COLS + c;
                w.p4[c] = colours[cell_idx][PLANE4_BIT];
                w.p5[c] = colours[cell_idx][PLANE5_BIT];
                w.p6[c] = colours[cell_idx][PLANE6_BIT];
            end
            scan_words_due.push_back(w);
            cur_row  = row;
            prev_row = row;
        end
    endtask

    // driver: one word on the slave side at a time, wait count drawn per word
    always @(posedge i_clk) begin : drive
        t_midi_item cur;
        t_midi_item nxt;
        bit         presenting;
        int         waited;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            waited = 0;
        end else begin
            presenting = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                update_matrix(cur);
                presenting = 1'b0;
            end
            if (!presenting && pending_events.size() != 0) begin
                nxt = pending_events[0];
                if (waited < nxt.gap) begin
                    waited++;
                end else if (!(nxt.drain && scan_words_due.size() != 0)) begin
                    cur = pending_events.pop_front();
                    s_axis_tdata <= {2'b00, cur.vel, cur.note, cur.status};
                    s_axis_tuser <= cur.mode;
                    presenting = 1'b1;
                    waited = 0;
                end
            end
            s_axis_tvalid <= presenting;
        end
    end

    // monitor: compare each scan word with the oldest prediction, stall after some words
    always @(posedge i_clk) begin : watch
        t_scan_res got;
        t_scan_res want;
        int        stall_left;
        bit        rx_burst;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            rx_burst = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_scan_res'(m_axis_tdata[$bits(t_scan_res)-1:0]);
                if (scan_words_due.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_axis_tdata), 0);
                end else begin
                    want = scan_words_due.pop_front();
                    if (got.row_off !== want.row_off)
                        report_mismatch("row_off", int'(got.row_off), int'(want.row_off));
                    if (got.row_on !== want.row_on)
                        report_mismatch("row_on", int'(got.row_on), int'(want.row_on));
                    if (got.p4 !== want.p4)
                        report_mismatch("plane_bit4_cols", int'(got.p4), int'(want.p4));
                    if (got.p5 !== want.p5)
                        report_mismatch("plane_bit5_cols", int'(got.p5), int'(want.p5));
                    if (got.p6 !== want.p6)
                        report_mismatch("plane_bit6_cols", int'(got.p6), int'(want.p6));
                end
                n_checked++;
                if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        int         counted;
        int         r;
        logic [7:0] st;
        logic [6:0] nt;

        foreach (colours[i]) colours[i] = '0;
        cur_row  = 0;
        prev_row = 0;

        // directed: first tick after reset, extremes, ignored events, zero velocity, clear
        queue_event(MODE_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)), 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd1, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h9F, 7'd64, 7'h70, 1'b0);
        queue_event(MODE_NOTE, 8'h95, 7'd9, 7'h10, 1'b0);
        queue_event(MODE_NOTE, 8'h95, 7'd10, 7'h20, 1'b0);
        queue_event(MODE_NOTE, 8'h95, 7'd11, 7'h40, 1'b0);
        queue_event(MODE_NOTE, 8'h80, 7'd2, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'hFF, 7'd3, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd0, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd65, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd127, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd8, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h90, 7'd1, 7'h00, 1'b0);
        // walk every row, wrapping back through row 0
        repeat (ROWS) queue_event(MODE_TICK, 8'hFF, 7'h7F, 7'h7F, 1'b0);
        queue_event(MODE_NOTE, 8'h9A, CLEAR_NOTE, 7'h55, 1'b1);
        repeat (3) queue_event(MODE_TICK, 8'h00, 7'h00, 7'h00, 1'b0);

        counted = 0;
        while (counted < RAND_ITEMS) begin
            if ($urandom_range(0, 49) == 0) sender_burst = !sender_burst;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_event(MODE_NOTE, {NOTE_ON_NIBBLE, 4'($urandom_range(0, 15))},
                            7'($urandom_range(FIRST_NOTE, CELLS)),
                            7'($urandom_range(0, 127)), 1'b0);
                counted++;
            end else if (r < 80) begin
                // let the sender run dry now and then before a tick
                queue_event(MODE_TICK, 8'($urandom_range(0, 255)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                            (counted % 400) == 399);
                counted++;
            end else if (r < 81) begin
                queue_event(MODE_NOTE, {NOTE_ON_NIBBLE, 4'($urandom_range(0, 15))},
                            CLEAR_NOTE, 7'($urandom_range(0, 127)), 1'b0);
                counted++;
            end else if (r < 90) begin
                st = 8'($urandom_range(0, 255));
                if (st[7:4] == NOTE_ON_NIBBLE) st[7:4] = OFF_NIBBLE;
                queue_event(MODE_NOTE, st, 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 1'b0);
                counted++;
            end else begin
                nt = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(CELLS + 1, 127));
                if (nt == CLEAR_NOTE) nt = 7'h7F;
                queue_event(MODE_NOTE, {NOTE_ON_NIBBLE, 4'($urandom_range(0, 15))}, nt,
                            7'($urandom_range(0, 127)), 1'b0);
                counted++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (scan_words_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d cell writes, %0d store clears, %0d ignored events",
                 n_writes, n_clears, n_ignored);
        $display("checked %0d scan words across all %0d rows", n_checked, ROWS);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("timeout waiting for scan words");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
